// File: hdl/ieas_pkg.sv
// Package for the EEPROM access sequencer: phase, command and status codes,
// and the item and result structs shared by the control and top level.
// No dependencies.
package ieas_pkg;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_START   = 4'd1,
        PH_SLAW    = 4'd2,
        PH_ADDRH   = 4'd3,
        PH_ADDRL   = 4'd4,
        PH_DATA    = 4'd5,
        PH_RESTART = 4'd6,
        PH_SLAR    = 4'd7,
        PH_RECV    = 4'd8
    } t_phase;

    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_START    = 3'd1,
        CMD_SEND     = 3'd2,
        CMD_RECVNACK = 3'd3,
        CMD_STOP     = 3'd4
    } t_cmd;

    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_STATUS = 2'd2;

    localparam logic [7:0] ST_MASK     = 8'hF8;
    localparam logic [7:0] ST_START    = 8'h08;
    localparam logic [7:0] ST_RESTART  = 8'h10;
    localparam logic [7:0] ST_SLAW_ACK = 8'h18;
    localparam logic [7:0] ST_DATA_ACK = 8'h28;
    localparam logic [7:0] ST_SLAR_ACK = 8'h40;
    localparam logic [7:0] ST_RX_NACK  = 8'h58;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  device_address;
        logic [15:0] memory_address;
        logic [7:0]  write_data;
        logic [7:0]  bus_status;
        logic [7:0]  received_byte;
    } t_item;

    typedef struct packed {
        t_cmd       command;
        logic [7:0] tx_byte;
        logic       done_res;
        logic       ok;
        logic [7:0] read_data;
    } t_res;

endpackage

// File: hdl/ieas_ctrl.sv
// Access phase machine: holds the request and the phase, and forms the
// result for one item combinationally. Depends on ieas_pkg.
module ieas_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  ieas_pkg::t_item i_item,
    output ieas_pkg::t_res  o_res
);
    import ieas_pkg::*;

    t_phase      r_phase, n_phase;
    logic        r_read_pending, n_read_pending;
    logic [7:0]  r_device, n_device;
    logic [15:0] r_location, n_location;
    logic [7:0]  r_data, n_data;

    logic [7:0] st;
    logic       is_req;
    logic       is_status;
    logic       start_ok;

    assign st        = i_item.bus_status & ST_MASK;
    assign is_req    = (i_item.action == ACT_WRITE) || (i_item.action == ACT_READ);
    assign is_status = (i_item.action == ACT_STATUS);
    assign start_ok  = (st == ST_START) || (st == ST_RESTART);

    always_comb begin
        n_phase        = r_phase;
        n_read_pending = r_read_pending;
        n_device       = r_device;
        n_location     = r_location;
        n_data         = r_data;
        if (is_req) begin
            if (r_phase == PH_IDLE) begin
                n_device       = i_item.device_address;
                n_location     = i_item.memory_address;
                n_data         = i_item.write_data;
                n_read_pending = (i_item.action == ACT_READ);
                n_phase        = PH_START;
            end
        end else if (is_status) begin
            unique case (r_phase)
                PH_IDLE:    n_phase = PH_IDLE;
                PH_START:   n_phase = start_ok ? PH_SLAW : PH_IDLE;
                PH_SLAW:    n_phase = (st == ST_SLAW_ACK) ? PH_ADDRH : PH_START;
                PH_ADDRH:   n_phase = (st == ST_DATA_ACK) ? PH_ADDRL : PH_IDLE;
                PH_ADDRL: begin
                    if (st != ST_DATA_ACK) begin
                        n_phase = PH_IDLE;
                    end else if (r_read_pending) begin
                        n_phase = PH_RESTART;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA:    n_phase = PH_IDLE;
                PH_RESTART: n_phase = start_ok ? PH_SLAR : PH_IDLE;
                PH_SLAR:    n_phase = (st == ST_SLAR_ACK) ? PH_RECV : PH_IDLE;
                PH_RECV:    n_phase = PH_IDLE;
                default:    n_phase = PH_IDLE;
            endcase
        end
    end

    always_comb begin
        o_res = '0;
        if (is_req) begin
            if (r_phase == PH_IDLE) begin
                o_res.command = CMD_START;
            end
        end else if (is_status) begin
            unique case (r_phase)
                PH_IDLE: o_res = '0;
                PH_START: begin
                    if (start_ok) begin
                        o_res.command = CMD_SEND;
                        o_res.tx_byte = r_device;
                    end else begin
                        o_res.done_res = 1'b1;
                    end
                end
                PH_SLAW: begin
                    if (st == ST_SLAW_ACK) begin
                        o_res.command = CMD_SEND;
                        o_res.tx_byte = r_location[15:8];
                    end else begin
                        o_res.command = CMD_START;
                    end
                end
                PH_ADDRH: begin
                    if (st == ST_DATA_ACK) begin
                        o_res.command = CMD_SEND;
                        o_res.tx_byte = r_location[7:0];
                    end else begin
                        o_res.done_res = 1'b1;
                    end
                end
                PH_ADDRL: begin
                    if (st != ST_DATA_ACK) begin
                        o_res.done_res = 1'b1;
                    end else if (r_read_pending) begin
                        o_res.command = CMD_START;
                    end else begin
                        o_res.command = CMD_SEND;
                        o_res.tx_byte = r_data;
                    end
                end
                PH_DATA: begin
                    o_res.done_res = 1'b1;
                    if (st == ST_DATA_ACK) begin
                        o_res.command = CMD_STOP;
                        o_res.ok      = 1'b1;
                    end
                end
                PH_RESTART: begin
                    if (start_ok) begin
                        o_res.command = CMD_SEND;
                        o_res.tx_byte = r_device | 8'h01;
                    end else begin
                        o_res.done_res = 1'b1;
                    end
                end
                PH_SLAR: begin
                    if (st == ST_SLAR_ACK) begin
                        o_res.command = CMD_RECVNACK;
                    end else begin
                        o_res.done_res = 1'b1;
                    end
                end
                PH_RECV: begin
                    o_res.done_res = 1'b1;
                    if (st == ST_RX_NACK) begin
                        o_res.command   = CMD_STOP;
                        o_res.ok        = 1'b1;
                        o_res.read_data = i_item.received_byte;
                    end
                end
                default: o_res = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_read_pending <= 1'b0;
            r_device       <= '0;
            r_location     <= '0;
            r_data         <= '0;
        end else if (i_en) begin
            r_phase        <= n_phase;
            r_read_pending <= n_read_pending;
            r_device       <= n_device;
            r_location     <= n_location;
            r_data         <= n_data;
        end
    end

`ifndef ASSERT_OFF
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && o_res.done_res |=> r_phase == PH_IDLE)
        else $error("phase not idle after access end");
    a_ok_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.ok |-> o_res.done_res)
        else $error("ok without done");
    a_rd_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.read_data != 8'h00 |-> o_res.ok)
        else $error("read data on failed access");
    a_req_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && is_req && r_phase == PH_IDLE |=> r_phase == PH_START)
        else $error("request did not start access");
`endif

endmodule

// File: hdl/i2c_eeprom_access_sequencer.sv
// Top level of the EEPROM access sequencer: input register, phase machine
// and result register. Depends on ieas_pkg and ieas_ctrl.
//
//  channel  | direction | tdata                         | tuser  | tlast
//  s_axis   | in        | dev, loc, wdata, status, rx   | action | -
//  m_axis   | out       | command, tx_byte, ok, rd_data | -      | done_res
//
// One item per cycle unless the result stalls.
// The phase register updates as an item moves from the input register
// to the result register. Reset (synchronous, active low) returns to idle.
// A stalled result holds the pipeline; tready falls only when both stages fill.
module i2c_eeprom_access_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] device_address, [23:8] memory_address, [31:24] write_data,
    // [39:32] bus_status, [47:40] received_byte
    input  logic [47:0] s_axis_tdata,
    // [1:0] action
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] command, [10:3] tx_byte, [11] ok, [19:12] read_data, [23:20] zero
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import ieas_pkg::*;

    logic  r_in_valid;
    t_item r_item;
    logic  r_out_valid;
    t_res  r_res;
    t_res  step_res;
    logic  advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item.action         <= s_axis_tuser;
            r_item.device_address <= s_axis_tdata[7:0];
            r_item.memory_address <= s_axis_tdata[23:8];
            r_item.write_data     <= s_axis_tdata[31:24];
            r_item.bus_status     <= s_axis_tdata[39:32];
            r_item.received_byte  <= s_axis_tdata[47:40];
        end
    end

    ieas_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_item  (r_item),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= step_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_res.done_res;
    assign m_axis_tdata  = {4'b0000, r_res.read_data, r_res.ok, r_res.tx_byte,
                            r_res.command};

endmodule

// File: test/i2c_eeprom_access_sequencer_tb.sv
// Self-checking testbench for i2c_eeprom_access_sequencer: drives write, read and
// status items, predicts each engine command in step and checks every result item.
// Depends on ieas_pkg and the sequencer RTL.
module i2c_eeprom_access_sequencer_tb;
    import ieas_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;

    t_phase      model_phase = PH_IDLE;
    logic        model_read = 1'b0;
    logic [7:0]  model_dev = '0;
    logic [15:0] model_loc = '0;
    logic [7:0]  model_data = '0;

    t_res        due_commands[$];
    bit          idling = 1'b1;
    int unsigned sink_hold = 0;
    int          mismatch_count = 0;
    int          results_checked = 0;
    int          access_items = 0;
    int          accesses_run = 0;
    int          reads_run = 0;
    int          polls_run = 0;
    int          aborted_accesses = 0;

    i2c_eeprom_access_sequencer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_res sequence_step(input t_item it);
        t_res       r;
        logic [7:0] st;
        logic       bad;
        r   = '0;
        st  = it.bus_status & ST_MASK;
        bad = 1'b0;
        if (it.action == ACT_WRITE || it.action == ACT_READ) begin
            if (model_phase == PH_IDLE) begin
                model_dev   = it.device_address;
                model_loc   = it.memory_address;
                model_data  = it.write_data;
                model_read  = (it.action == ACT_READ);
                model_phase = PH_START;
                r.command   = CMD_START;
            end
        end else if (it.action == ACT_STATUS) begin
            case (model_phase)
                PH_START: begin
                    if (st == ST_START || st == ST_RESTART) begin
                        r.command = CMD_SEND;
                        r.tx_byte = model_dev;
                        model_phase = PH_SLAW;
                    end else bad = 1'b1;
                end
                PH_SLAW: begin
                    if (st == ST_SLAW_ACK) begin
                        r.command = CMD_SEND;
                        r.tx_byte = model_loc[15:8];
                        model_phase = PH_ADDRH;
                    end else begin
                        r.command = CMD_START;
                        model_phase = PH_START;
                    end
                end
                PH_ADDRH: begin
                    if (st == ST_DATA_ACK) begin
                        r.command = CMD_SEND;
                        r.tx_byte = model_loc[7:0];
                        model_phase = PH_ADDRL;
                    end else bad = 1'b1;
                end
                PH_ADDRL: begin
                    if (st != ST_DATA_ACK) bad = 1'b1;
                    else if (model_read) begin
                        r.command = CMD_START;
                        model_phase = PH_RESTART;
                    end else begin
                        r.command = CMD_SEND;
                        r.tx_byte = model_data;
                        model_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (st == ST_DATA_ACK) begin
                        r.command  = CMD_STOP;
                        r.done_res = 1'b1;
                        r.ok       = 1'b1;
                        model_phase = PH_IDLE;
                    end else bad = 1'b1;
                end
                PH_RESTART: begin
                    if (st == ST_START || st == ST_RESTART) begin
                        r.command = CMD_SEND;
                        r.tx_byte = model_dev | 8'h01;
                        model_phase = PH_SLAR;
                    end else bad = 1'b1;
                end
                PH_SLAR: begin
                    if (st == ST_SLAR_ACK) begin
                        r.command = CMD_RECVNACK;
                        model_phase = PH_RECV;
                    end else bad = 1'b1;
                end
                PH_RECV: begin
                    if (st == ST_RX_NACK) begin
                        r.command   = CMD_STOP;
                        r.done_res  = 1'b1;
                        r.ok        = 1'b1;
                        r.read_data = it.received_byte;
                        model_phase = PH_IDLE;
                    end else bad = 1'b1;
                end
                default: model_phase = PH_IDLE;
            endcase
        end
        if (bad) begin
            r = '0;
            r.done_res = 1'b1;
            model_phase = PH_IDLE;
            aborted_accesses++;
        end
        return r;
    endfunction

    function automatic t_item random_item(input logic [1:0] act);
        t_item it;
        it.action         = act;
        it.device_address = 8'($urandom);
        it.memory_address = 16'($urandom);
        it.write_data     = 8'($urandom);
        it.bus_status     = 8'($urandom);
        it.received_byte  = 8'($urandom);
        return it;
    endfunction

    function automatic logic [7:0] status_for(input t_phase ph, input bit pass);
        logic [7:0] want;
        logic [7:0] st;
        logic       start_ph;
        start_ph = (ph == PH_START || ph == PH_RESTART);
        case (ph)
            PH_START, PH_RESTART:      want = $urandom_range(0, 1) ? ST_START : ST_RESTART;
            PH_SLAW:                   want = ST_SLAW_ACK;
            PH_ADDRH, PH_ADDRL, PH_DATA: want = ST_DATA_ACK;
            PH_SLAR:                   want = ST_SLAR_ACK;
            default:                   want = ST_RX_NACK;
        endcase
        if (pass) return want | 8'($urandom_range(0, 7));
        st = 8'($urandom);
        while (start_ph ? ((st & ST_MASK) == ST_START || (st & ST_MASK) == ST_RESTART)
                        : ((st & ST_MASK) == want))
            st = 8'($urandom);
        return st;
    endfunction

    task automatic send_item(input t_item it);
        if (idling && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.received_byte, it.bus_status, it.write_data,
                          it.memory_address, it.device_address};
        s_axis_tuser  <= it.action;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        due_commands.push_back(sequence_step(it));
    endtask

    task automatic send_request(input logic [1:0] act, input logic [7:0] dev,
                                input logic [15:0] loc, input logic [7:0] data);
        t_item it;
        it = random_item(act);
        it.device_address = dev;
        it.memory_address = loc;
        it.write_data     = data;
        send_item(it);
    endtask

    task automatic send_status(input logic [7:0] st, input logic [7:0] rx);
        t_item it;
        it = random_item(ACT_STATUS);
        it.bus_status    = st;
        it.received_byte = rx;
        send_item(it);
    endtask

    // ignored item: status or unused code when idle, request or unused code when busy
    task automatic send_noise();
        t_item it;
        it = random_item(ACT_UNUSED);
        if ($urandom_range(0, 1) == 0)
            it.action = (model_phase == PH_IDLE) ? ACT_STATUS
                      : ($urandom_range(0, 1) ? ACT_READ : ACT_WRITE);
        send_item(it);
    endtask

    task automatic drive_access(input logic [1:0] kind, input logic [7:0] dev,
                                input logic [15:0] loc, input logic [7:0] data,
                                input int polls, input int break_at, input bit noisy,
                                input logic [7:0] rx);
        int step;
        step = 0;
        accesses_run++;
        if (kind == ACT_READ) reads_run++;
        send_request(kind, dev, loc, data);
        access_items++;
        while (model_phase != PH_IDLE) begin
            if (noisy && $urandom_range(0, 9) == 0) begin
                send_noise();
            end else if (model_phase == PH_SLAW && polls > 0) begin
                send_status(status_for(PH_SLAW, 1'b0), rx);
                polls--;
                polls_run++;
                access_items++;
            end else begin
                send_status(status_for(model_phase, step != break_at), rx);
                step++;
                access_items++;
            end
        end
    endtask

    task automatic test_write_access();
        send_request(ACT_WRITE, 8'hFF, 16'hFFFF, 8'hFF);
        send_status(8'h0F, 8'hFF);
        send_status(8'h1F, 8'hFF);
        send_status(8'h2F, 8'hFF);
        send_status(8'h2F, 8'hFF);
        send_status(8'h2F, 8'hFF);
        drive_access(ACT_WRITE, 8'h00, 16'h0000, 8'h00, 0, -1, 1'b0, 8'h00);
    endtask

    task automatic test_read_access();
        send_request(ACT_READ, 8'hFE, 16'h8001, 8'h00);
        send_status(8'h10, 8'h00);
        send_status(8'h18, 8'h00);
        send_status(8'h28, 8'h00);
        send_status(8'h28, 8'h00);
        send_status(8'h17, 8'h00);
        send_status(8'h47, 8'h00);
        send_status(8'h5F, 8'hFF);
        drive_access(ACT_READ, 8'h00, 16'h0000, 8'hFF, 0, -1, 1'b0, 8'h00);
    endtask

    task automatic test_ack_polling();
        drive_access(ACT_WRITE, 8'hA0, 16'h0100, 8'h5A, 3, -1, 1'b0, 8'h00);
    endtask

    task automatic test_error_paths();
        send_status(ST_START, 8'h00);
        send_item(random_item(ACT_UNUSED));
        send_request(ACT_READ, 8'hA2, 16'h1234, 8'h77);
        send_request(ACT_WRITE, 8'h55, 16'hAAAA, 8'h33);
        send_status(8'h00, 8'h00);
        drive_access(ACT_READ, 8'hA4, 16'h00FF, 8'h00, 0, 6, 1'b0, 8'hFF);
    endtask

    task automatic test_random_traffic();
        logic [1:0] kind;
        int         polls;
        int         brk;
        while (access_items < 1200) begin
            if (access_items >= 1000) idling = 1'b0;
            kind  = $urandom_range(0, 1) ? ACT_READ : ACT_WRITE;
            polls = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
            brk   = ($urandom_range(0, 4) == 0)
                  ? $urandom_range(0, (kind == ACT_READ) ? 6 : 4) : -1;
            if ($urandom_range(0, 5) == 0) send_noise();
            drive_access(kind, 8'($urandom), 16'($urandom), 8'($urandom),
                         polls, brk, 1'b1, 8'($urandom));
        end
    endtask

    always @(posedge i_clk) begin
        if (sink_hold != 0) begin
            sink_hold     <= sink_hold - 1;
            m_axis_tready <= (sink_hold == 1);
        end else if (idling && $urandom_range(0, 5) == 0) begin
            sink_hold     <= $urandom_range(1, 6);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_result
        t_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (due_commands.size() == 0) begin
                $error("unexpected result item: tdata 'h%0h tlast %0b",
                       m_axis_tdata, m_axis_tlast);
                mismatch_count++;
            end else begin
                want = due_commands.pop_front();
                compare_field("command", want.command, m_axis_tdata[2:0]);
                compare_field("tx_byte", want.tx_byte, m_axis_tdata[10:3]);
                compare_field("done_res", want.done_res, m_axis_tlast);
                compare_field("ok", want.ok, m_axis_tdata[11]);
                compare_field("read_data", want.read_data, m_axis_tdata[19:12]);
                results_checked++;
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_write_access();
        test_read_access();
        test_ack_polling();
        test_error_paths();
        test_random_traffic();
        s_axis_tvalid <= 1'b0;
        while (due_commands.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        $display("Ran %0d accesses (%0d reads, %0d ended on bad status, %0d polling retries)",
                 accesses_run, reads_run, aborted_accesses, polls_run);
        $display("Checked %0d result items against the prediction", results_checked);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timed out with %0d results outstanding", due_commands.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
hdl/ieas_pkg.sv
hdl/ieas_ctrl.sv
hdl/i2c_eeprom_access_sequencer.sv
test/i2c_eeprom_access_sequencer_tb.sv
